>>> hw/rtl/mfbc_pkg.sv
package mfbc_pkg;

    localparam int ROUND_COUNT_DEF = 16;
    localparam int KEY_W           = 8;
    localparam int NIB_W           = 4;
    localparam int RKEY_W          = 6;
    localparam int SCHED_LEN       = 16;

    // data carried from one round cell to the next
    typedef struct packed {
        logic             op;
        logic [NIB_W-1:0] l;
        logic [NIB_W-1:0] r;
    } mfbc_stage_t;

    typedef logic [RKEY_W-1:0] mfbc_rkey_t;

    // des s-box 1, row by column
    localparam logic [3:0] SBOX1 [4][16] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7},
        '{4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
          4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8},
        '{4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
          4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0},
        '{4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
          4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13}
    };

    // accumulated nibble rotation per round, modulo four
    localparam logic [1:0] CUM_ROT [SCHED_LEN] = '{
        2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2,
        2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd0
    };

    function automatic logic [NIB_W-1:0] rotl4(input logic [NIB_W-1:0] v,
                                               input logic [1:0] amt);
        logic [2*NIB_W-1:0] dbl;
        dbl = {v, v} << amt;
        return dbl[2*NIB_W-1:NIB_W];
    endfunction

    // round key for schedule position idx
    function automatic mfbc_rkey_t round_key(input logic [KEY_W-1:0] key,
                                             input logic [3:0] idx);
        logic [KEY_W-1:0]  k1;
        logic [NIB_W-1:0]  c;
        logic [NIB_W-1:0]  d;
        logic [RKEY_W-1:0] v;
        mfbc_rkey_t        res;
        k1 = {key[KEY_W-2:0], key[KEY_W-1]};
        c  = rotl4(k1[KEY_W-1:NIB_W], CUM_ROT[idx]);
        d  = rotl4(k1[NIB_W-1:0], CUM_ROT[idx]);
        v  = {c[2:0], d[2:0]};
        for (int i = 0; i < RKEY_W; i++) begin
            res[RKEY_W-1-i] = v[i];
        end
        return res;
    endfunction

    // feistel round function
    function automatic logic [NIB_W-1:0] round_f(input logic [NIB_W-1:0] r,
                                                 input mfbc_rkey_t k);
        logic [RKEY_W-1:0] x;
        logic [3:0]        s;
        x = {r[0], r[3], r[2], r[1], r[0], r[2]} ^ k;
        s = SBOX1[{x[5], x[0]}][x[4:1]];
        return rotl4(s, 2'd1);
    endfunction

endpackage

>>> hw/rtl/mfbc_key_sched.sv
module mfbc_key_sched
    import mfbc_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [KEY_W-1:0] cfg_wr_data,
    output mfbc_rkey_t       key_enc [ROUND_COUNT],
    output mfbc_rkey_t       key_dec [ROUND_COUNT]
);

    logic [KEY_W-1:0] cipher_key_reg;
    logic [KEY_W-1:0] cipher_key_next;

    // key register write
    always_comb begin
        cipher_key_next = cfg_wr_en ? cfg_wr_data : cipher_key_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cipher_key_reg <= '0;
        end else begin
            cipher_key_reg <= cipher_key_next;
        end
    end

    // per round keys for both directions
    for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_keys
        localparam logic [3:0] ENC_IDX = 4'(i);
        localparam logic [3:0] DEC_IDX = 4'(ROUND_COUNT - 1 - i);
        assign key_enc[i] = round_key(cipher_key_reg, ENC_IDX);
        assign key_dec[i] = round_key(cipher_key_reg, DEC_IDX);
    end

endmodule

>>> hw/rtl/mfbc_round_cell.sv
module mfbc_round_cell
    import mfbc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  mfbc_stage_t in_data,
    input  mfbc_rkey_t  key_enc,
    input  mfbc_rkey_t  key_dec,
    output logic        out_valid,
    input  logic        out_ready,
    output mfbc_stage_t out_data
);

    logic        valid_reg;
    logic        valid_next;
    mfbc_stage_t data_reg;
    mfbc_stage_t data_next;
    mfbc_rkey_t  rkey;
    logic        load;

    // cell loads when empty or when its transaction moves on
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign rkey     = in_data.op ? key_dec : key_enc;

    // one feistel round
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        if (load) begin
            data_next.op = in_data.op;
            data_next.l  = in_data.r;
            data_next.r  = in_data.l ^ round_f(in_data.r, rkey);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled round cell lost or changed its transaction");
    a_load_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> valid_reg)
        else $error("accepted transaction missing from round cell");
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> valid_reg && !out_ready)
        else $error("round cell refused input while able to move");
`endif

endmodule

>>> hw/rtl/mini_feistel_byte_cipher_top.sv
// each round cell registers one round on the way from input transaction to result
// throughput: one block per cycle while the result is taken; each cell frees as soon as its neighbor takes its data
// a stalled result holds the last cell and each full cell behind it; earlier cells keep filling bubbles
// reset (aresetn low, synchronous) empties every cell and sets the key to zero
// key writes reach all cells at once through the combinational round key schedule
module mini_feistel_byte_cipher_top
    import mfbc_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [KEY_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_op,
    input  logic [7:0]       s_block_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_block_out
);

    mfbc_rkey_t  key_enc [ROUND_COUNT];
    mfbc_rkey_t  key_dec [ROUND_COUNT];
    logic        valid_c [ROUND_COUNT+1];
    logic        ready_c [ROUND_COUNT+1];
    mfbc_stage_t data_c  [ROUND_COUNT+1];

    mfbc_key_sched #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_key_sched (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .key_enc     (key_enc),
        .key_dec     (key_dec)
    );

    // input split into halves
    assign valid_c[0]   = s_valid;
    assign s_ready      = ready_c[0];
    assign data_c[0].op = s_op;
    assign data_c[0].l  = s_block_in[7:4];
    assign data_c[0].r  = s_block_in[3:0];

    // chain of round cells
    for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_cell
        mfbc_round_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_c[i]),
            .in_ready  (ready_c[i]),
            .in_data   (data_c[i]),
            .key_enc   (key_enc[i]),
            .key_dec   (key_dec[i]),
            .out_valid (valid_c[i+1]),
            .out_ready (ready_c[i+1]),
            .out_data  (data_c[i+1])
        );
    end

    // result with final halves swapped
    assign ready_c[ROUND_COUNT] = m_ready;
    assign m_valid              = valid_c[ROUND_COUNT];
    assign m_block_out          = {data_c[ROUND_COUNT].r, data_c[ROUND_COUNT].l};

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mfbc_pkg::*;

    localparam int ROUNDS     = ROUND_COUNT_DEF;
    localparam int STUCK_MAX  = 1000;
    localparam int HOLD_OFF   = 120;
    localparam int MAX_REPORT = 10;

    // des s-box 1, row by column
    localparam logic [3:0] DES_S1 [4][16] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7},
        '{4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
          4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8},
        '{4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
          4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0},
        '{4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
          4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13}
    };

    // per-round nibble rotation of the key schedule, applied cumulatively
    localparam int KEY_SHIFTS [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

    // corner blocks for the directed part
    localparam logic [7:0] CORNER_BLOCKS [10] = '{
        8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F
    };

    typedef struct packed {
        logic       op;
        logic [7:0] blk;
    } cipher_req_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [KEY_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    logic             s_op        = 1'b0;
    logic [7:0]       s_block_in  = 8'h00;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    logic [7:0]       m_block_out;

    cipher_req_t      pending_blocks[$];
    logic [7:0]       expected_blocks[$];
    logic [KEY_W-1:0] model_key      = '0;
    int               send_idle_pct  = 25;
    int               recv_idle_pct  = 56;
    int               stall_requests = 0;
    int               stall_served   = 0;
    int               stall_left     = 0;
    int               stuck_cycles   = 0;
    int               mismatch_count = 0;

    mini_feistel_byte_cipher_top #(
        .ROUND_COUNT(ROUNDS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_block_in  (s_block_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_block_out (m_block_out)
    );

    always #4 aclk = ~aclk;

    // expected cipher output for one block under the given key
    function automatic logic [7:0] cipher_block(input logic [KEY_W-1:0] key,
                                                input logic decrypt,
                                                input logic [7:0] blk);
        logic [7:0]       rot_key;
        logic [NIB_W-1:0] c_half;
        logic [NIB_W-1:0] d_half;
        logic [NIB_W-1:0] left;
        logic [NIB_W-1:0] right;
        logic [NIB_W-1:0] sbox_out;
        logic [NIB_W-1:0] new_right;
        logic [5:0]       sched [16];
        logic [5:0]       joined;
        logic [5:0]       x;
        logic [3:0]       idx;
        rot_key = {key[6:0], key[7]};
        c_half  = rot_key[7:4];
        d_half  = rot_key[3:0];
        // round keys: rotate both halves, join low bits, reverse
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < KEY_SHIFTS[i]; j++) begin
                c_half = {c_half[2:0], c_half[3]};
                d_half = {d_half[2:0], d_half[3]};
            end
            joined = {c_half[2:0], d_half[2:0]};
            for (int b = 0; b < 6; b++) begin
                sched[i][5-b] = joined[b];
            end
        end
        left  = blk[7:4];
        right = blk[3:0];
        // feistel rounds, schedule reversed for decryption
        for (int i = 0; i < ROUNDS; i++) begin
            idx       = 4'(decrypt ? (ROUNDS - 1 - i) : i);
            x         = {right[0], right[3], right[2], right[1], right[0], right[2]}
                        ^ sched[idx];
            sbox_out  = DES_S1[{x[5], x[0]}][x[4:1]];
            new_right = left ^ {sbox_out[2:0], sbox_out[3]};
            left      = right;
            right     = new_right;
        end
        return {right, left};
    endfunction

    // input driver: offers queued blocks, random gaps between transactions
    always @(posedge aclk) begin : block_sender
        if (s_valid && !s_ready) begin
            // hold the current transaction until it is taken
        end else if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            s_valid    <= 1'b1;
            s_op       <= pending_blocks[0].op;
            s_block_in <= pending_blocks[0].blk;
            pending_blocks.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // monitor: records accepted inputs, checks results, drives m_ready
    always @(posedge aclk) begin : block_checker
        logic [7:0] want;
        logic       moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_blocks.push_back(cipher_block(model_key, s_op, s_block_in));
                moved = 1'b1;
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (expected_blocks.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORT)
                        $display("unexpected result %02h with nothing pending", m_block_out);
                end else begin
                    want = expected_blocks.pop_front();
                    if (m_block_out !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORT)
                            $display("block_out mismatch: expected %02h, got %02h",
                                     want, m_block_out);
                    end
                end
            end
        end
        stuck_cycles <= moved ? 0 : stuck_cycles + 1;

        // receiver readiness, with an occasional long hold-off
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (stall_served != stall_requests) begin
            stall_served <= stall_served + 1;
            stall_left   <= HOLD_OFF;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    initial begin : watchdog
        while (stuck_cycles < STUCK_MAX) @(negedge aclk);
        $display("FAILURE");
        $finish;
    end

    task automatic load_key(input logic [KEY_W-1:0] k);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        model_key   <= k;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic queue_random(input int count);
        cipher_req_t req;
        for (int i = 0; i < count; i++) begin
            req.op  = 1'($urandom_range(1));
            req.blk = 8'($urandom_range(255));
            pending_blocks.push_back(req);
        end
    endtask

    // wait until every queued block has come back, then let the pipe settle
    task automatic drain();
        while (pending_blocks.size() != 0 || s_valid || expected_blocks.size() != 0)
            @(negedge aclk);
        repeat (ROUNDS + 4) @(negedge aclk);
    endtask

    initial begin : sequencer
        cipher_req_t req;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed corners, both directions, all-zero key
        load_key(8'h00);
        foreach (CORNER_BLOCKS[i]) begin
            req.op  = 1'b0;
            req.blk = CORNER_BLOCKS[i];
            pending_blocks.push_back(req);
            req.op  = 1'b1;
            pending_blocks.push_back(req);
        end
        drain();

        // sender sparse, receiver sparser
        load_key(8'hFF);
        queue_random(150);
        drain();
        load_key(8'h80);
        queue_random(150);
        drain();

        // roles swapped
        send_idle_pct = 56;
        recv_idle_pct = 25;
        load_key(KEY_W'($urandom_range(255)));
        queue_random(150);
        drain();
        load_key(8'h01);
        queue_random(150);
        drain();

        // full rate, with a long receiver hold-off that backs up the pipe
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_key(KEY_W'($urandom_range(255)));
        stall_requests = stall_requests + 1;
        queue_random(150);
        drain();

        // full rate, sender pauses until all results are back
        load_key(KEY_W'($urandom_range(255)));
        queue_random(75);
        drain();
        queue_random(75);
        drain();

        if (mismatch_count == 0 && expected_blocks.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
